// ===== hdl/rvie_pkg.sv =====
`default_nettype none

package rvie_pkg;

  localparam int unsigned OP_W        = 4;
  localparam int unsigned REG_FIELD_W = 6;
  localparam int unsigned REG_CODES   = 2 ** REG_FIELD_W;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned FLAG_W      = 2;
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_USED_W  = WORD_W + 1 + REG_FIELD_W + WORD_W + FLAG_W + 2;

  localparam logic [OP_W-1:0] OP_ADD     = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB     = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV     = 4'd3;
  localparam logic [OP_W-1:0] OP_CMP     = 4'd4;
  localparam logic [OP_W-1:0] OP_COPY    = 4'd5;
  localparam logic [OP_W-1:0] OP_JUMP    = 4'd6;
  localparam logic [OP_W-1:0] OP_LOADIMM = 4'd7;
  localparam logic [OP_W-1:0] OP_LOADKEY = 4'd8;
  localparam logic [OP_W-1:0] OP_PRINT   = 4'd9;
  localparam logic [OP_W-1:0] OP_HALT    = 4'd10;

  localparam logic [FLAG_W-1:0] FLAG_ZERO = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_POS  = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_NEG  = 2'd2;

  localparam logic [REG_FIELD_W-1:0] JC_ALWAYS  = 6'd0;
  localparam logic [REG_FIELD_W-1:0] JC_ZERO    = 6'd1;
  localparam logic [REG_FIELD_W-1:0] JC_NZERO   = 6'd2;
  localparam logic [REG_FIELD_W-1:0] JC_POS     = 6'd3;
  localparam logic [REG_FIELD_W-1:0] JC_NEG     = 6'd4;
  localparam logic [REG_FIELD_W-1:0] JC_NOT_NEG = 6'd5;
  localparam logic [REG_FIELD_W-1:0] JC_NOT_POS = 6'd6;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_CMP
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [FLAG_W-1:0] flag;
    logic [FLAG_W-1:0] rem_flag;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/rvie_ram.sv =====
`default_nettype none

module rvie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== hdl/rvie_alu.sv =====
`default_nettype none

module rvie_alu #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  rvie_pkg::alu_req_t      req_i,
  input  wire  [DATA_WIDTH-1:0]   a_i,
  input  wire  [DATA_WIDTH-1:0]   b_i,
  output rvie_pkg::alu_rsp_t      rsp_o,
  output logic [DATA_WIDTH-1:0]   res_o,
  output logic [DATA_WIDTH-1:0]   rem_o
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_ITER = 2'd1;
  localparam logic [1:0] P_FIX  = 2'd2;
  localparam logic [1:0] P_DONE = 2'd3;

  logic [1:0]              phase_q;
  rvie_pkg::alu_op_e       op_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [DATA_WIDTH-1:0]   acc_q;
  logic [DATA_WIDTH-1:0]   x_q;
  logic [DATA_WIDTH-1:0]   y_q;
  logic [DATA_WIDTH-1:0]   rem_q;
  logic                    qneg_q;
  logic                    rneg_q;
  logic [rvie_pkg::FLAG_W-1:0] cflag_q;
  logic [DATA_WIDTH:0]     trial;

  function automatic logic [rvie_pkg::FLAG_W-1:0] flag_of(input logic [DATA_WIDTH-1:0] v);
    if (v == '0) begin
      return rvie_pkg::FLAG_ZERO;
    end
    return v[DATA_WIDTH-1] ? rvie_pkg::FLAG_NEG : rvie_pkg::FLAG_POS;
  endfunction

  assign trial = {rem_q, x_q[DATA_WIDTH-1]} - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      op_q    <= rvie_pkg::ALU_ADD;
      cnt_q   <= '0;
    end else begin
      case (phase_q)
        P_IDLE: begin
          if (req_i.start) begin
            op_q <= req_i.op;
            cnt_q <= CNT_W'(DATA_WIDTH);
            case (req_i.op)
              rvie_pkg::ALU_MUL: phase_q <= P_ITER;
              rvie_pkg::ALU_DIV: phase_q <= (b_i == '0) ? P_DONE : P_ITER;
              default:           phase_q <= P_DONE;
            endcase
          end
        end
        P_ITER: begin
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNT_W'(1)) begin
            phase_q <= (op_q == rvie_pkg::ALU_DIV) ? P_FIX : P_DONE;
          end
        end
        P_FIX:   phase_q <= P_DONE;
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      P_IDLE: begin
        if (req_i.start) begin
          case (req_i.op)
            rvie_pkg::ALU_ADD: acc_q <= a_i + b_i;
            rvie_pkg::ALU_SUB: acc_q <= a_i - b_i;
            rvie_pkg::ALU_CMP: begin
              if (a_i == b_i) begin
                cflag_q <= rvie_pkg::FLAG_ZERO;
              end else if ($signed(a_i) > $signed(b_i)) begin
                cflag_q <= rvie_pkg::FLAG_POS;
              end else begin
                cflag_q <= rvie_pkg::FLAG_NEG;
              end
            end
            rvie_pkg::ALU_MUL: begin
              acc_q <= '0;
              x_q   <= a_i;
              y_q   <= b_i;
            end
            rvie_pkg::ALU_DIV: begin
              if (b_i == '0) begin
                acc_q <= '0;
                rem_q <= a_i;
              end else begin
                x_q    <= a_i[DATA_WIDTH-1] ? -a_i : a_i;
                y_q    <= b_i[DATA_WIDTH-1] ? -b_i : b_i;
                rem_q  <= '0;
                qneg_q <= a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
                rneg_q <= a_i[DATA_WIDTH-1];
              end
            end
            default: acc_q <= acc_q;
          endcase
        end
      end
      P_ITER: begin
        if (op_q == rvie_pkg::ALU_MUL) begin
          if (y_q[0]) begin
            acc_q <= acc_q + x_q;
          end
          x_q <= {x_q[DATA_WIDTH-2:0], 1'b0};
          y_q <= {1'b0, y_q[DATA_WIDTH-1:1]};
        end else if (!trial[DATA_WIDTH]) begin
          rem_q <= trial[DATA_WIDTH-1:0];
          x_q   <= {x_q[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[DATA_WIDTH-2:0], x_q[DATA_WIDTH-1]};
          x_q   <= {x_q[DATA_WIDTH-2:0], 1'b0};
        end
      end
      P_FIX: begin
        acc_q <= qneg_q ? -x_q : x_q;
        rem_q <= rneg_q ? -rem_q : rem_q;
      end
      default: acc_q <= acc_q;
    endcase
  end

  assign rsp_o.done     = (phase_q == P_DONE);
  assign rsp_o.flag     = (op_q == rvie_pkg::ALU_CMP) ? cflag_q : flag_of(acc_q);
  assign rsp_o.rem_flag = flag_of(rem_q);
  assign res_o          = acc_q;
  assign rem_o          = rem_q;

endmodule

`default_nettype wire

// ===== hdl/register_vm_instruction_execute.sv =====
// Register machine instruction executor.
// Input beats on the s_axis channel carry one decoded instruction each: the
// opcode in tuser, register fields, immediate and key value in tdata. Every
// accepted beat yields exactly one result beat on m_axis with the next
// program counter, print output, sign flag and the halt and bad-opcode marks.
// Operands are read from the register store one port at a time, then the
// instruction runs on a shared iterative unit (shift-add multiply, restoring
// divide, one bit per cycle). After an accepted beat the block steps through
// operand read A, operand read B and execute; an arithmetic op then waits on
// the unit, a divide writes its remainder to the second register, and the
// result beat is loaded from the done state before the next beat is taken.
// The result sits in an output register, so the next beat is taken while it
// waits; if the receiver stalls and a second result is ready, the block holds
// in its final state until the output register frees.
// Reset clears the register store (per-entry valid bits), the flag, the
// counter and the halt mark at once; the block leaves reset ready for a beat.
`default_nettype none

module register_vm_instruction_execute #(
  parameter int unsigned NUM_REGS   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  // first_reg, second_reg, immediate, key_value
  input  wire  [rvie_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // op
  input  wire  [rvie_pkg::OP_W-1:0]             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  // next_pc, print_valid, print_reg, print_value, flag_state, halted, bad_opcode
  output logic [rvie_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(NUM_REGS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_RDB  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;
  localparam logic [2:0] S_WRR  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  function automatic logic [rvie_pkg::REG_CODES-1:0][IDX_W-1:0] build_map();
    logic [rvie_pkg::REG_CODES-1:0][IDX_W-1:0] m;
    for (int i = 0; i < rvie_pkg::REG_CODES; i++) begin
      m[i] = IDX_W'(i % NUM_REGS);
    end
    return m;
  endfunction

  localparam logic [rvie_pkg::REG_CODES-1:0][IDX_W-1:0] REG_MAP = build_map();

  logic [2:0]                          state_q;
  logic [rvie_pkg::OP_W-1:0]           op_q;
  logic [rvie_pkg::REG_FIELD_W-1:0]    f1_q;
  logic [IDX_W-1:0]                    d_q;
  logic [IDX_W-1:0]                    s_q;
  logic signed [rvie_pkg::WORD_W-1:0]  imm_q;
  logic signed [rvie_pkg::WORD_W-1:0]  key_q;
  logic [DATA_WIDTH-1:0]               a_q;
  logic [DATA_WIDTH-1:0]               b_q;
  logic [rvie_pkg::WORD_W-1:0]         pc_q;
  logic [rvie_pkg::FLAG_W-1:0]         flag_q;
  logic                                halt_q;
  logic                                pv_q;
  logic [rvie_pkg::WORD_W-1:0]         pval_q;
  logic                                bad_q;
  logic [NUM_REGS-1:0]                 vld_q;
  logic                                rvld_q;
  logic                                m_valid_q;
  logic [rvie_pkg::OUT_TDATA_W-1:0]    out_data_q;

  logic                                in_beat;
  logic                                out_free;
  logic                                arith_op;
  logic                                jmp_ok;
  logic [rvie_pkg::WORD_W-1:0]         pc_inc;
  logic                                we;
  logic [IDX_W-1:0]                    waddr;
  logic [DATA_WIDTH-1:0]               wdata;
  logic [IDX_W-1:0]                    raddr;
  logic [DATA_WIDTH-1:0]               rdata;
  logic [DATA_WIDTH-1:0]               rd_val;
  rvie_pkg::alu_req_t                  alu_req;
  rvie_pkg::alu_rsp_t                  alu_rsp;
  logic [DATA_WIDTH-1:0]               alu_res;
  logic [DATA_WIDTH-1:0]               alu_rem;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign arith_op      = op_q inside {rvie_pkg::OP_ADD, rvie_pkg::OP_SUB, rvie_pkg::OP_MUL,
                                      rvie_pkg::OP_DIV, rvie_pkg::OP_CMP};
  assign pc_inc        = pc_q + 1'b1;
  assign raddr         = (state_q == S_IDLE) ?
                         REG_MAP[s_axis_tdata[rvie_pkg::REG_FIELD_W-1:0]] : s_q;
  assign rd_val        = rvld_q ? rdata : '0;

  always_comb begin
    case (f1_q)
      rvie_pkg::JC_ALWAYS:  jmp_ok = 1'b1;
      rvie_pkg::JC_ZERO:    jmp_ok = (flag_q == rvie_pkg::FLAG_ZERO);
      rvie_pkg::JC_NZERO:   jmp_ok = (flag_q != rvie_pkg::FLAG_ZERO);
      rvie_pkg::JC_POS:     jmp_ok = (flag_q == rvie_pkg::FLAG_POS);
      rvie_pkg::JC_NEG:     jmp_ok = (flag_q == rvie_pkg::FLAG_NEG);
      rvie_pkg::JC_NOT_NEG: jmp_ok = (flag_q != rvie_pkg::FLAG_NEG);
      rvie_pkg::JC_NOT_POS: jmp_ok = (flag_q != rvie_pkg::FLAG_POS);
      default:              jmp_ok = 1'b0;
    endcase
  end

  always_comb begin
    alu_req.start = 1'b0;
    alu_req.op    = rvie_pkg::ALU_ADD;
    if (state_q == S_EXEC && !halt_q) begin
      alu_req.start = arith_op;
      case (op_q)
        rvie_pkg::OP_SUB: alu_req.op = rvie_pkg::ALU_SUB;
        rvie_pkg::OP_MUL: alu_req.op = rvie_pkg::ALU_MUL;
        rvie_pkg::OP_DIV: alu_req.op = rvie_pkg::ALU_DIV;
        rvie_pkg::OP_CMP: alu_req.op = rvie_pkg::ALU_CMP;
        default:          alu_req.op = rvie_pkg::ALU_ADD;
      endcase
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = d_q;
    wdata = b_q;
    case (state_q)
      S_EXEC: begin
        if (!halt_q) begin
          case (op_q)
            rvie_pkg::OP_COPY: we = 1'b1;
            rvie_pkg::OP_LOADIMM: begin
              we    = 1'b1;
              wdata = DATA_WIDTH'(imm_q);
            end
            rvie_pkg::OP_LOADKEY: begin
              we    = 1'b1;
              wdata = DATA_WIDTH'(key_q);
            end
            default: we = 1'b0;
          endcase
        end
      end
      S_WAIT: begin
        we    = alu_rsp.done && (op_q != rvie_pkg::OP_CMP);
        wdata = alu_res;
      end
      S_WRR: begin
        we    = 1'b1;
        waddr = s_q;
        wdata = alu_rem;
      end
      default: we = 1'b0;
    endcase
  end

  rvie_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (NUM_REGS)
  ) u_rvie_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rvie_alu #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_rvie_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (a_q),
    .b_i    (b_q),
    .rsp_o  (alu_rsp),
    .res_o  (alu_res),
    .rem_o  (alu_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pc_q      <= '0;
      flag_q    <= rvie_pkg::FLAG_ZERO;
      halt_q    <= 1'b0;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[raddr];
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (state_q == S_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_beat) begin
            state_q <= S_RDA;
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: state_q <= S_EXEC;
        S_EXEC: begin
          state_q <= (!halt_q && arith_op) ? S_WAIT : S_DONE;
          if (!halt_q) begin
            case (op_q)
              rvie_pkg::OP_COPY,
              rvie_pkg::OP_LOADIMM,
              rvie_pkg::OP_LOADKEY,
              rvie_pkg::OP_PRINT: pc_q <= pc_inc;
              rvie_pkg::OP_HALT: begin
                halt_q <= 1'b1;
                pc_q   <= pc_inc;
              end
              rvie_pkg::OP_JUMP: begin
                pc_q <= (jmp_ok && imm_q != '0) ? pc_q + imm_q : pc_inc;
              end
              default: pc_q <= pc_q;
            endcase
          end
        end
        S_WAIT: begin
          if (alu_rsp.done) begin
            pc_q <= pc_inc;
            if (op_q == rvie_pkg::OP_DIV && d_q == s_q) begin
              flag_q <= alu_rsp.rem_flag;
            end else begin
              flag_q <= alu_rsp.flag;
            end
            state_q <= (op_q == rvie_pkg::OP_DIV) ? S_WRR : S_DONE;
          end
        end
        S_WRR: state_q <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q  <= s_axis_tuser;
      f1_q  <= s_axis_tdata[5:0];
      d_q   <= REG_MAP[s_axis_tdata[5:0]];
      s_q   <= REG_MAP[s_axis_tdata[11:6]];
      imm_q <= s_axis_tdata[43:12];
      key_q <= s_axis_tdata[75:44];
    end
    if (state_q == S_RDA) begin
      a_q <= rd_val;
    end
    if (state_q == S_RDB) begin
      b_q <= rd_val;
    end
    if (state_q == S_EXEC) begin
      pv_q   <= !halt_q && (op_q == rvie_pkg::OP_PRINT);
      pval_q <= (!halt_q && op_q == rvie_pkg::OP_PRINT) ? rvie_pkg::WORD_W'(a_q) : '0;
      bad_q  <= !halt_q && (op_q > rvie_pkg::OP_HALT);
    end
    if (state_q == S_DONE && out_free) begin
      out_data_q <= {(rvie_pkg::OUT_TDATA_W - rvie_pkg::OUT_USED_W)'(0),
                     bad_q,
                     halt_q,
                     flag_q,
                     pval_q,
                     pv_q ? rvie_pkg::REG_FIELD_W'(d_q) : rvie_pkg::REG_FIELD_W'(0),
                     pv_q,
                     pc_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
